[sv/c128b_pkg.sv]
// Package: shared types, constants, pattern table and checksum helpers.
`default_nettype none

package c128b_pkg;

  localparam int unsigned MODULUS   = 103;
  localparam int unsigned START_B   = 104;
  localparam int unsigned STOP_VAL  = 106;
  localparam int unsigned CHAR_LO   = 32;
  localparam int unsigned CHAR_HI   = 127;
  localparam int unsigned VALUE_W   = 7;
  localparam int unsigned PATTERN_W = 11;
  localparam int unsigned PROD_W    = 2 * VALUE_W;
  localparam int unsigned HI_DEPTH  = 2 ** VALUE_W;
  localparam int unsigned HI_STEP   = HI_DEPTH - MODULUS;
  localparam int unsigned ROM_DEPTH = STOP_VAL + 1;

  typedef logic [VALUE_W-1:0]   value_t;
  typedef logic [PATTERN_W-1:0] pattern_t;
  typedef logic [PROD_W-1:0]    prod_t;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_CHECK = 2'd2,
    KIND_STOP  = 2'd3
  } kind_t;

  typedef struct packed {
    logic   bad;
    logic   start;
    logic   last;
    value_t value;
    prod_t  prod;
  } entry_t;

  localparam pattern_t PATTERN_ROM [ROM_DEPTH] = '{
    11'h6CC, 11'h66C, 11'h666, 11'h498, 11'h48C, 11'h44C, 11'h4C8, 11'h4C4, 11'h464, 11'h648,
    11'h644, 11'h624, 11'h59C, 11'h4DC, 11'h4CE, 11'h5CC, 11'h4EC, 11'h4E6, 11'h672, 11'h65C,
    11'h64E, 11'h6E4, 11'h674, 11'h76E, 11'h74C, 11'h72C, 11'h726, 11'h764, 11'h734, 11'h732,
    11'h6D8, 11'h6C6, 11'h636, 11'h518, 11'h458, 11'h446, 11'h588, 11'h468, 11'h462, 11'h688,
    11'h628, 11'h622, 11'h5B8, 11'h58E, 11'h46E, 11'h5D8, 11'h5C6, 11'h476, 11'h776, 11'h68E,
    11'h62E, 11'h6E8, 11'h6E2, 11'h6EE, 11'h758, 11'h746, 11'h716, 11'h768, 11'h762, 11'h71A,
    11'h77A, 11'h642, 11'h78A, 11'h530, 11'h50C, 11'h4B0, 11'h486, 11'h42C, 11'h426, 11'h590,
    11'h584, 11'h4D0, 11'h4C2, 11'h434, 11'h432, 11'h612, 11'h650, 11'h7BA, 11'h614, 11'h47A,
    11'h53C, 11'h4BC, 11'h49E, 11'h5E4, 11'h4F4, 11'h4F2, 11'h7A4, 11'h794, 11'h792, 11'h6DE,
    11'h6F6, 11'h7B6, 11'h578, 11'h51E, 11'h45E, 11'h5E8, 11'h5E2, 11'h7A8, 11'h7A2, 11'h5DE,
    11'h5EE, 11'h75E, 11'h7AE, 11'h684, 11'h690, 11'h69C, 11'h63A
  };

  typedef value_t hi_tab_t [HI_DEPTH];

  function automatic hi_tab_t build_hi_tab();
    hi_tab_t     t;
    int unsigned acc;
    acc = 0;
    for (int i = 0; i < HI_DEPTH; i++) begin
      t[i] = VALUE_W'(acc);
      acc  = acc + HI_STEP;
      if (acc >= MODULUS) acc = acc - MODULUS;
    end
    return t;
  endfunction

  // (i * 128) mod 103 for each upper half of a product
  localparam hi_tab_t HI_MOD = build_hi_tab();

  function automatic pattern_t pattern_of(value_t v);
    pattern_t p;
    p = '0;
    if (v <= VALUE_W'(STOP_VAL)) p = PATTERN_ROM[v];
    return p;
  endfunction

  // (sum + prod) mod 103, sum already reduced
  function automatic value_t mod_add(value_t sum, prod_t prod);
    logic [VALUE_W:0] r;
    logic [VALUE_W:0] s;
    r = {1'b0, HI_MOD[prod[PROD_W-1:VALUE_W]]} + {1'b0, prod[VALUE_W-1:0]};
    if (r >= (VALUE_W+1)'(MODULUS)) r = r - (VALUE_W+1)'(MODULUS);
    if (r >= (VALUE_W+1)'(MODULUS)) r = r - (VALUE_W+1)'(MODULUS);
    s = {1'b0, sum} + r;
    if (s >= (VALUE_W+1)'(MODULUS)) s = s - (VALUE_W+1)'(MODULUS);
    return s[VALUE_W-1:0];
  endfunction

endpackage

`default_nettype wire

[sv/c128b_front.sv]
// Front end: accept characters, classify them, track run position and weight.
`default_nettype none

module c128b_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [7:0]        character,
  input  wire logic              last_char,
  input  wire logic              full,
  output logic                   push,
  output c128b_pkg::entry_t      push_data
);

  logic                in_run;
  c128b_pkg::value_t   weight;
  c128b_pkg::value_t   weight_use;
  c128b_pkg::value_t   weight_next;
  logic                bad;

  always_comb begin
    in_stall    = full;
    push        = in_valid && !full;
    bad         = (character < 8'(c128b_pkg::CHAR_LO)) || (character > 8'(c128b_pkg::CHAR_HI));
    weight_use  = in_run ? weight : c128b_pkg::VALUE_W'(1);
    weight_next = (weight_use == c128b_pkg::VALUE_W'(c128b_pkg::MODULUS - 1)) ?
                  '0 : weight_use + c128b_pkg::VALUE_W'(1);
    push_data.bad   = bad;
    push_data.start = !bad && !in_run;
    push_data.last  = last_char;
    push_data.value = c128b_pkg::VALUE_W'(character - 8'(c128b_pkg::CHAR_LO));
    push_data.prod  = {{c128b_pkg::VALUE_W{1'b0}}, push_data.value} *
                      {{c128b_pkg::VALUE_W{1'b0}}, weight_use};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_run <= 1'b0;
      weight <= c128b_pkg::VALUE_W'(1);
    end else if (push) begin
      if (bad || last_char) begin
        in_run <= 1'b0;
        weight <= c128b_pkg::VALUE_W'(1);
      end else begin
        in_run <= 1'b1;
        weight <= weight_next;
      end
    end
  end

endmodule

`default_nettype wire

[sv/c128b_queue.sv]
// Queue: short FIFO of classified items between front and back.
`default_nettype none

module c128b_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire c128b_pkg::entry_t  push_data,
  input  wire logic               pop,
  output c128b_pkg::entry_t       head,
  output logic                    empty,
  output logic                    full
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(DEPTH - 1);

  c128b_pkg::entry_t  mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  always_comb begin
    empty = (count == '0);
    full  = (count == CNT_W'(DEPTH));
    head  = mem[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == LAST_IDX) ? '0 : wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= (rd_ptr == LAST_IDX) ? '0 : rd_ptr + PTR_W'(1);
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

[sv/c128b_back.sv]
// Back end: sequence start, data, check and stop symbols into the output register.
`default_nettype none

module c128b_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               empty,
  input  wire c128b_pkg::entry_t  head,
  output logic                    pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [10:0]             bar_pattern,
  output logic [6:0]              symbol_value,
  output logic [1:0]              symbol_kind,
  output logic                    run_done,
  output logic                    bad_char
);

  typedef enum logic [3:0] {
    PH_FIRST = 4'b0001,
    PH_DATA  = 4'b0010,
    PH_CHECK = 4'b0100,
    PH_STOP  = 4'b1000
  } phase_t;

  phase_t               phase;
  phase_t               phase_next;
  c128b_pkg::value_t    sum;
  c128b_pkg::value_t    sum_next;
  logic                 load;
  logic                 data_now;
  c128b_pkg::value_t    o_value;
  c128b_pkg::kind_t     o_kind;
  logic                 o_done;
  logic                 o_bad;

  always_comb begin
    load       = !empty && (!out_valid || !out_stall);
    pop        = 1'b0;
    phase_next = phase;
    sum_next   = sum;
    data_now   = 1'b0;
    o_value    = '0;
    o_kind     = c128b_pkg::KIND_DATA;
    o_done     = 1'b0;
    o_bad      = 1'b0;
    unique case (phase)
      PH_FIRST: begin
        if (head.start) begin
          o_value    = c128b_pkg::VALUE_W'(c128b_pkg::START_B);
          o_kind     = c128b_pkg::KIND_START;
          sum_next   = c128b_pkg::VALUE_W'(c128b_pkg::START_B - c128b_pkg::MODULUS);
          phase_next = PH_DATA;
        end else begin
          data_now = 1'b1;
        end
      end
      PH_DATA: data_now = 1'b1;
      PH_CHECK: begin
        o_value    = sum;
        o_kind     = c128b_pkg::KIND_CHECK;
        phase_next = PH_STOP;
      end
      PH_STOP: begin
        o_value    = c128b_pkg::VALUE_W'(c128b_pkg::STOP_VAL);
        o_kind     = c128b_pkg::KIND_STOP;
        o_done     = 1'b1;
        pop        = load;
        phase_next = PH_FIRST;
      end
      default: phase_next = PH_FIRST;
    endcase
    if (data_now) begin
      o_kind = c128b_pkg::KIND_DATA;
      if (head.bad) begin
        o_bad      = 1'b1;
        o_done     = 1'b1;
        pop        = load;
        phase_next = PH_FIRST;
      end else begin
        o_value  = head.value;
        sum_next = c128b_pkg::mod_add(sum, head.prod);
        if (head.last) begin
          phase_next = PH_CHECK;
        end else begin
          pop        = load;
          phase_next = PH_FIRST;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_FIRST;
      sum       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        phase     <= phase_next;
        sum       <= sum_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bar_pattern  <= o_bad ? '0 : c128b_pkg::pattern_of(o_value);
      symbol_value <= o_value;
      symbol_kind  <= o_kind;
      run_done     <= o_done;
      bad_char     <= o_bad;
    end
  end

endmodule

`default_nettype wire

[sv/code128b_symbol_encoder_top.sv]
// Top level: Code 128 set B encoder, front end, item queue and symbol back end.
// The first result of an item passes through its queue entry and then the back end's output register.
// Throughput: one input transfer per cycle while the queue has room; the back end
// sends one result per cycle while an item waits and out_stall is low, one to four per item (start, data, check, stop).
// The back end's single output register sets the sustained rate of the block.
// Reset (rst, synchronous): empties the queue, drops any open run, clears out_valid.
`default_nettype none

module code128b_symbol_encoder_top #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  character,
  input  wire logic        last_char,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [10:0]      bar_pattern,
  output logic [6:0]       symbol_value,
  output logic [1:0]       symbol_kind,
  output logic             run_done,
  output logic             bad_char
);

  logic               q_push;
  logic               q_pop;
  logic               q_empty;
  logic               q_full;
  c128b_pkg::entry_t  q_in;
  c128b_pkg::entry_t  q_head;

  c128b_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .character (character),
    .last_char (last_char),
    .full      (q_full),
    .push      (q_push),
    .push_data (q_in)
  );

  c128b_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  c128b_back u_back (
    .clk          (clk),
    .rst          (rst),
    .empty        (q_empty),
    .head         (q_head),
    .pop          (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .bar_pattern  (bar_pattern),
    .symbol_value (symbol_value),
    .symbol_kind  (symbol_kind),
    .run_done     (run_done),
    .bad_char     (bad_char)
  );

endmodule

`default_nettype wire

[sv/c128b_checker.sv]
// Checker: port-level assertions for the encoder top level, with its bind.
`default_nettype none

module c128b_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [10:0] bar_pattern,
  input wire logic [6:0]  symbol_value,
  input wire logic [1:0]  symbol_kind,
  input wire logic        run_done,
  input wire logic        bad_char
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(symbol_value) && $stable(symbol_kind))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  a_bad_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_char |-> bar_pattern == '0 && run_done &&
      symbol_kind == c128b_pkg::KIND_DATA && symbol_value == '0)
    else $error("malformed error result");

  a_stop_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && symbol_kind == c128b_pkg::KIND_STOP |->
      run_done && symbol_value == 7'(c128b_pkg::STOP_VAL))
    else $error("stop symbol malformed");

  a_check_then_stop: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && symbol_kind == c128b_pkg::KIND_CHECK |=>
      out_valid && symbol_kind == c128b_pkg::KIND_STOP)
    else $error("check symbol not followed by stop");

endmodule

bind code128b_symbol_encoder_top c128b_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .bar_pattern  (bar_pattern),
  .symbol_value (symbol_value),
  .symbol_kind  (symbol_kind),
  .run_done     (run_done),
  .bad_char     (bad_char)
);

`default_nettype wire
